FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by heartbeat_zero_crossing_detector_unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define HZCD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define HZCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/hzcd_pkg.sv
// ----------------------------------------------------------------------------
// hzcd_pkg
// types, constants and the low-pass tap table of the heartbeat detector
// ----------------------------------------------------------------------------
`default_nettype none

package hzcd_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int FRAC_W     = 15;
   localparam int DC_ACC_W   = SAMPLE_W + FRAC_W;
   localparam int TAP_W      = 13;
   localparam int FIR_HALF   = 11;
   localparam int FIR_LAST   = 2 * FIR_HALF;
   localparam int TAP_IDX_W  = 4;
   localparam int BACK_W     = 5;
   localparam int PROD_W     = SAMPLE_W + TAP_W + 1;
   localparam int FIR_ACC_W  = SAMPLE_W + FRAC_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [SAMPLE_W-1:0] SPAN_LOWER_RESET = 16'd20;
   localparam logic [SAMPLE_W-1:0] SPAN_UPPER_RESET = 16'd1000;
   localparam logic signed [SAMPLE_W-1:0] PEAK_RESET   = 16'sd20;
   localparam logic signed [SAMPLE_W-1:0] TROUGH_RESET = -16'sd20;

   // half of the symmetric 23-tap kernel, center tap last
   localparam logic [TAP_W-1:0] FIR_TAPS [FIR_HALF+1] = '{
      13'd172,  13'd321,  13'd579,  13'd927,  13'd1360, 13'd1858,
      13'd2390, 13'd2916, 13'd3391, 13'd3768, 13'd4012, 13'd4096
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_ENABLE = 2'd0,
      CSR_FALLING_EDGE  = 2'd1,
      CSR_SPAN_LOWER    = 2'd2,
      CSR_SPAN_UPPER    = 2'd3
   } hzcd_csr_type;

   typedef struct packed {
      logic load_sample;
      logic dc_update;
      logic ac_update;
      logic fir_issue;
      logic detect;
   } hzcd_cmd_type;

   typedef struct packed {
      logic filter_enable;
      logic fir_busy;
   } hzcd_status_type;

endpackage

`default_nettype wire

FILE: rtl/hzcd_ram.sv
// ----------------------------------------------------------------------------
// hzcd_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module hzcd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]  rd_data_a,
   output logic      [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: rtl/hzcd_ctrl.sv
// ----------------------------------------------------------------------------
// hzcd_ctrl
// sequencer: dc update, ac, filter taps, drain, detection and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module hzcd_ctrl import hzcd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire hzcd_status_type      status,
   output hzcd_cmd_type              cmd,
   output logic      [TAP_IDX_W-1:0] tap_index
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DC,
      ST_AC,
      ST_FIR,
      ST_DRAIN,
      ST_DETECT
   } state_type;

   localparam logic [TAP_IDX_W-1:0] TAP_LAST = TAP_IDX_W'(FIR_HALF);

   state_type            state_ff, state_in;
   logic [TAP_IDX_W-1:0] tap_ff, tap_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DC;
            end
         end
         ST_DC: begin
            state_in = ST_AC;
         end
         ST_AC: begin
            tap_in   = '0;
            state_in = status.filter_enable ? ST_FIR : ST_DETECT;
         end
         ST_FIR: begin
            tap_in = tap_ff + 1'b1;
            if (tap_ff == TAP_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last product lands in the accumulator on this edge
            if (!status.fir_busy) begin
               state_in = ST_DETECT;
            end
         end
         ST_DETECT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd             = '0;
      cmd.load_sample = (state_ff == ST_IDLE) && req_valid;
      cmd.dc_update   = (state_ff == ST_DC);
      cmd.ac_update   = (state_ff == ST_AC);
      cmd.fir_issue   = (state_ff == ST_FIR);
      cmd.detect      = (state_ff == ST_DETECT) && out_free;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign tap_index = tap_ff;

endmodule

`default_nettype wire

FILE: rtl/hzcd_datapath.sv
// ----------------------------------------------------------------------------
// hzcd_datapath
// dc tracker, history ring with pipelined symmetric mac, crossing detector
// ----------------------------------------------------------------------------
`default_nettype none

module hzcd_datapath import hzcd_pkg::*; #(
   parameter int DC_SMOOTH_SHIFT = 4,
   parameter int HISTORY_DEPTH   = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire hzcd_cmd_type                 cmd,
   input  wire logic        [TAP_IDX_W-1:0]  tap_index,
   output hzcd_status_type                   status,
   input  wire logic                         csr_wr_en,
   input  wire logic        [CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic        [SAMPLE_W-1:0]   req_sample,
   output logic                              rsp_beat,
   output logic signed      [SAMPLE_W-1:0]   rsp_ac_value,
   output logic             [SAMPLE_W-1:0]   rsp_dc_level
);

   localparam int PTR_W = $clog2(HISTORY_DEPTH);

   function automatic logic [PTR_W-1:0] ring_back(input logic [PTR_W-1:0]  ptr,
                                                  input logic [BACK_W-1:0] back);
      logic [PTR_W:0] diff;
      diff = {1'b0, ptr} - (PTR_W+1)'(back);
      if (diff[PTR_W]) begin
         diff = diff + (PTR_W+1)'(HISTORY_DEPTH);
      end
      return diff[PTR_W-1:0];
   endfunction

   // configuration
   logic                cfg_filter_ff, cfg_falling_ff;
   logic [SAMPLE_W-1:0] cfg_lower_ff, cfg_upper_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_filter_ff  <= 1'b0;
         cfg_falling_ff <= 1'b0;
         cfg_lower_ff   <= SPAN_LOWER_RESET;
         cfg_upper_ff   <= SPAN_UPPER_RESET;
      end else if (csr_wr_en) begin
         unique case (hzcd_csr_type'(csr_index))
            CSR_FILTER_ENABLE: cfg_filter_ff  <= csr_wdata[0];
            CSR_FALLING_EDGE:  cfg_falling_ff <= csr_wdata[0];
            CSR_SPAN_LOWER:    cfg_lower_ff   <= csr_wdata[SAMPLE_W-1:0];
            CSR_SPAN_UPPER:    cfg_upper_ff   <= csr_wdata[SAMPLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // dc tracker and ac
   logic        [SAMPLE_W-1:0] sample_ff;
   logic        [DC_ACC_W-1:0] dc_acc_ff, dc_acc_in;
   logic signed [DC_ACC_W:0]   dc_diff, dc_step;
   logic        [SAMPLE_W-1:0] dc_now;
   logic signed [SAMPLE_W-1:0] ac_raw, ac_ff;

   assign dc_diff   = $signed({1'b0, sample_ff, FRAC_W'(0)}) - $signed({1'b0, dc_acc_ff});
   assign dc_step   = dc_diff >>> DC_SMOOTH_SHIFT;
   assign dc_acc_in = dc_acc_ff + dc_step[DC_ACC_W-1:0];
   assign dc_now    = dc_acc_ff[DC_ACC_W-1:FRAC_W];
   assign ac_raw    = $signed(sample_ff - dc_now);

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= req_sample;
      end
      if (cmd.ac_update) begin
         ac_ff <= ac_raw;
      end
   end

   // history ring
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic                valid_ff [HISTORY_DEPTH];
   logic                ring_wr;
   logic [PTR_W-1:0]    addr_a, addr_b;
   logic [SAMPLE_W-1:0] ring_a, ring_b;

   assign ring_wr = cmd.ac_update && cfg_filter_ff;
   assign addr_a  = ring_back(ptr_ff, BACK_W'(tap_index));
   assign addr_b  = ring_back(ptr_ff, BACK_W'(FIR_LAST) - BACK_W'(tap_index));

   hzcd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock     (clock),
      .wr_en     (ring_wr),
      .wr_addr   (ptr_ff),
      .wr_data   (ac_raw),
      .rd_en     (cmd.fir_issue),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (ring_a),
      .rd_data_b (ring_b)
   );

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (ring_wr) begin
         valid_ff[ptr_ff] <= 1'b1;
      end
   end

   // mac pipeline: read, pair product, accumulate
   logic                        s1_en_ff, s2_en_ff;
   logic        [TAP_IDX_W-1:0] s1_tap_ff;
   logic                        va_ff, vb_ff;
   logic signed [SAMPLE_W-1:0]  pair_a, pair_b, pair_sum;
   logic signed [PROD_W-1:0]    prod_in, prod_ff;
   logic signed [FIR_ACC_W-1:0] fir_acc_ff, fir_acc_in;

   assign pair_a   = va_ff ? $signed(ring_a) : '0;
   assign pair_b   = (vb_ff && (s1_tap_ff != TAP_IDX_W'(FIR_HALF))) ? $signed(ring_b) : '0;
   assign pair_sum = pair_a + pair_b;
   assign prod_in  = PROD_W'(pair_sum * $signed({1'b0, FIR_TAPS[s1_tap_ff]}));

   always_comb begin
      fir_acc_in = fir_acc_ff;
      if (cmd.ac_update) begin
         fir_acc_in = '0;
      end else if (s2_en_ff) begin
         fir_acc_in = fir_acc_ff + FIR_ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_en_ff <= 1'b0;
         s2_en_ff <= 1'b0;
      end else begin
         s1_en_ff <= cmd.fir_issue;
         s2_en_ff <= s1_en_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fir_issue) begin
         s1_tap_ff <= tap_index;
         va_ff     <= valid_ff[addr_a];
         vb_ff     <= valid_ff[addr_b];
      end
      if (s1_en_ff) begin
         prod_ff <= prod_in;
      end
      fir_acc_ff <= fir_acc_in;
   end

   // crossing detector
   logic signed [SAMPLE_W-1:0] cur_ac, cur_ac_ff, cur_ac_in;
   logic signed [SAMPLE_W-1:0] lpeak_ff, lpeak_in, ltrough_ff, ltrough_in;
   logic signed [SAMPLE_W-1:0] rpeak_ff, rpeak_in, rtrough_ff, rtrough_in;
   logic                       pos_ff, pos_in, neg_ff, neg_in;
   logic                       rise, fall, span_ok, beat;
   logic signed [SAMPLE_W:0]   span;
   logic                       acc_en;

   assign cur_ac = cfg_filter_ff ? fir_acc_ff[FIR_ACC_W-1:FRAC_W] : ac_ff;
   assign rise   = (cur_ac_ff < 0) && (cur_ac >= 0);
   assign fall   = (cur_ac_ff > 0) && (cur_ac <= 0);
   assign acc_en = cmd.detect;

   always_comb begin
      cur_ac_in  = cur_ac_ff;
      lpeak_in   = lpeak_ff;
      ltrough_in = ltrough_ff;
      rpeak_in   = rpeak_ff;
      rtrough_in = rtrough_ff;
      pos_in     = pos_ff;
      neg_in     = neg_ff;
      if (acc_en) begin
         cur_ac_in = cur_ac;
         if (rise) begin
            lpeak_in   = rpeak_ff;
            ltrough_in = rtrough_ff;
            pos_in     = 1'b1;
            neg_in     = 1'b0;
            rpeak_in   = '0;
         end
         if (fall) begin
            pos_in     = 1'b0;
            neg_in     = 1'b1;
            rtrough_in = '0;
         end
         if (pos_in && (cur_ac > cur_ac_ff)) begin
            rpeak_in = cur_ac;
         end
         if (neg_in && (cur_ac < cur_ac_ff)) begin
            rtrough_in = cur_ac;
         end
      end
   end

   // a rising crossing judges the span it has just latched
   assign span    = (SAMPLE_W+1)'(lpeak_in) - (SAMPLE_W+1)'(ltrough_in);
   assign span_ok = (span > $signed({1'b0, cfg_lower_ff}))
                 && (span < $signed({1'b0, cfg_upper_ff}));
   assign beat    = span_ok && ((rise && !cfg_falling_ff) || (fall && cfg_falling_ff));

   always_comb begin
      ptr_in = ptr_ff;
      if (acc_en && cfg_filter_ff) begin
         ptr_in = (ptr_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_acc_ff  <= '0;
         ptr_ff     <= '0;
         cur_ac_ff  <= '0;
         lpeak_ff   <= PEAK_RESET;
         ltrough_ff <= TROUGH_RESET;
         rpeak_ff   <= '0;
         rtrough_ff <= '0;
         pos_ff     <= 1'b0;
         neg_ff     <= 1'b0;
      end else begin
         if (cmd.dc_update) begin
            dc_acc_ff <= dc_acc_in;
         end
         ptr_ff     <= ptr_in;
         cur_ac_ff  <= cur_ac_in;
         lpeak_ff   <= lpeak_in;
         ltrough_ff <= ltrough_in;
         rpeak_ff   <= rpeak_in;
         rtrough_ff <= rtrough_in;
         pos_ff     <= pos_in;
         neg_ff     <= neg_in;
      end
   end

   // result register
   logic                       rsp_beat_ff;
   logic signed [SAMPLE_W-1:0] rsp_ac_ff;
   logic        [SAMPLE_W-1:0] rsp_dc_ff;

   always_ff @(posedge clock) begin
      if (cmd.detect) begin
         rsp_beat_ff <= beat;
         rsp_ac_ff   <= cur_ac;
         rsp_dc_ff   <= dc_now;
      end
   end

   assign rsp_beat     = rsp_beat_ff;
   assign rsp_ac_value = rsp_ac_ff;
   assign rsp_dc_level = rsp_dc_ff;

   assign status.filter_enable = cfg_filter_ff;
   assign status.fir_busy      = s1_en_ff;

endmodule

`default_nettype wire

FILE: rtl/heartbeat_zero_crossing_detector_unit.sv
// ----------------------------------------------------------------------------
// heartbeat_zero_crossing_detector_unit
// one optical sensor sample in, one result (beat, ac value, dc level) out.
//
// req_*: one sample per transaction, valid/ready. rsp_*: one result per
// sample, valid/ready, in input order. csr_*: write-only register port, to
// be written by the user only while the unit is idle; it is not enforced.
// with the low-pass filter on, an accepted sample passes dc update, ac,
// the filter taps, the mac drain and detection; with it off, dc update,
// ac and detection. a new sample is taken only once the previous one is
// finished. the filter cost is set by its 12 pair reads from the dual-read
// history ram feeding a single shared multiplier, plus the pipeline drain.
// the result sits in an output register, so the next sample is accepted
// and processed while the receiver stalls; it waits in its final step
// only if the previous result has still not been taken.
// reset is synchronous: dc estimate, history (through per-entry valid
// bits), peak/trough state, control and configuration registers go to
// their reset values at once, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module heartbeat_zero_crossing_detector_unit import hzcd_pkg::*; #(
   parameter int DC_SMOOTH_SHIFT = 4,
   parameter int HISTORY_DEPTH   = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic        [SAMPLE_W-1:0]   req_sample,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_beat,
   output logic signed      [SAMPLE_W-1:0]   rsp_ac_value,
   output logic             [SAMPLE_W-1:0]   rsp_dc_level,
   input  wire logic                         csr_wr_en,
   input  wire logic        [CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [CSR_DATA_W-1:0] csr_wdata
);

   hzcd_cmd_type         cmd;
   hzcd_status_type      status;
   logic [TAP_IDX_W-1:0] tap_index;

   hzcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd),
      .tap_index (tap_index)
   );

   hzcd_datapath #(
      .DC_SMOOTH_SHIFT (DC_SMOOTH_SHIFT),
      .HISTORY_DEPTH   (HISTORY_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .tap_index    (tap_index),
      .status       (status),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_sample   (req_sample),
      .rsp_beat     (rsp_beat),
      .rsp_ac_value (rsp_ac_value),
      .rsp_dc_level (rsp_dc_level)
   );

   `HZCD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "sample accepted while one is in flight")
   `HZCD_ASSERT_SAME(a_fir_only_enabled, clock, reset, cmd.fir_issue, status.filter_enable, "filter taps read with filter disabled")
   `HZCD_ASSERT_SAME(a_detect_when_free, clock, reset, cmd.detect, !rsp_valid || rsp_ready, "result overwrites an untaken transaction")
   `HZCD_ASSERT_NEXT(a_detect_gives_rsp, clock, reset, cmd.detect, rsp_valid, "finished sample gave no result")

endmodule

`default_nettype wire
